// ===== src/cartridge_bank_address_mapper_top_assert.svh =====
// ----------------------------------------------------------------------------
// cartridge bank address mapper assertion macros
// shared property forms for the mapper checks, clocked on clk, reset by rst
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_ADDRESS_MAPPER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_ADDRESS_MAPPER_TOP_ASSERT_SVH

// same-cycle implication
`define CBAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbam_pkg.sv =====
// ----------------------------------------------------------------------------
// cbam_pkg
// widths and codes of the cartridge bank address mapper
// ----------------------------------------------------------------------------
package cbam_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int REGION_W   = 4;
  localparam int OFFSET_W   = 22;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int RAM_BANK_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KIND      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT = 1'd1;

  // controller kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MBC3 = 2'd3;

  // region codes
  localparam logic [REGION_W-1:0] RGN_BOOT   = 4'd0;
  localparam logic [REGION_W-1:0] RGN_FIXED  = 4'd1;
  localparam logic [REGION_W-1:0] RGN_BANKED = 4'd2;
  localparam logic [REGION_W-1:0] RGN_VRAM   = 4'd3;
  localparam logic [REGION_W-1:0] RGN_CART   = 4'd4;
  localparam logic [REGION_W-1:0] RGN_WRAM   = 4'd5;
  localparam logic [REGION_W-1:0] RGN_HRAM   = 4'd6;
  localparam logic [REGION_W-1:0] RGN_IO     = 4'd7;
  localparam logic [REGION_W-1:0] RGN_OPEN   = 4'd8;
  localparam logic [REGION_W-1:0] RGN_CTRL   = 4'd9;

  // ram enable data codes
  localparam logic [DATA_W-1:0] RAM_OFF = 8'h00;
  localparam logic [DATA_W-1:0] RAM_ON  = 8'h0A;

  localparam logic [ADDR_W-1:0] BOOT_OFF_ADDR = 16'hFF50;

endpackage

// ===== src/cartridge_bank_address_mapper_top.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_address_mapper_top
// decodes one bus access per cycle, unless in_stall holds it, into region and physical offset and
// updates the rom/ram bank control state of an mbc1/mbc3 style controller
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------
//  in       | sink      | in_valid / in_stall          | req_type, bus_address,
//           |           |                              | write_data
//  out      | source    | out_valid / out_stall        | region, offset, ignored
//  cfg      | sink      | cfg_write_en                 | cfg_index, cfg_data
//
//  one access per cycle while in_stall is low; the result appears in the output
//  register in the cycle after the transfer, set by the single decode stage in front of it
//  bank state is updated at the same edge the access is taken, so the next
//  access already sees it
//  reset (rst, synchronous) restores rom bank 1, ram unmapped, boot overlay on
//  in_stall is raised only while a result waits and out_stall holds it
// ----------------------------------------------------------------------------
module cartridge_bank_address_mapper_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [cbam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbam_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [cbam_pkg::ADDR_W-1:0]     bus_address,
  input  logic [cbam_pkg::DATA_W-1:0]     write_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbam_pkg::REGION_W-1:0]   region,
  output logic [cbam_pkg::OFFSET_W-1:0]   offset,
  output logic                           ignored
);
  import cbam_pkg::*;

  logic [KIND_W-1:0]     controller_kind;
  logic [COUNT_W-1:0]    ram_bank_count;
  logic [DATA_W-1:0]     rom_bank;
  logic                  ram_mapped;
  logic [RAM_BANK_W-1:0] mapped_bank;
  logic                  saved_valid;
  logic [RAM_BANK_W-1:0] saved_bank;
  logic                  boot_overlay;

  logic [DATA_W-1:0]     rom_bank_next;
  logic                  ram_mapped_next;
  logic [RAM_BANK_W-1:0] mapped_bank_next;
  logic                  saved_valid_next;
  logic [RAM_BANK_W-1:0] saved_bank_next;
  logic                  boot_overlay_next;

  logic [REGION_W-1:0]   region_next;
  logic [OFFSET_W-1:0]   offset_next;
  logic                  ignored_next;

  logic                  in_xfer;
  logic [COUNT_W-1:0]    bank_limit;
  logic                  kind_ok;
  logic                  rom_win;
  logic                  en_win;
  logic                  ram_win;
  logic                  ctrl_taken;
  logic [DATA_W-1:0]     rom_value;

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign bank_limit = (ram_bank_count > COUNT_W'(4)) ? COUNT_W'(4) : ram_bank_count;
  assign kind_ok    = (controller_kind == KIND_MBC1) || (controller_kind == KIND_MBC3);
  assign rom_win    = (bus_address >= 16'h2000) && (bus_address < 16'h3FFF);
  assign en_win     = bus_address < 16'h1FFF;
  assign ram_win    = (controller_kind == KIND_MBC3) &&
                      (bus_address >= 16'h4000) && (bus_address < 16'h5FFF);

  always_comb begin
    rom_value = write_data;
    if (rom_value == 8'h00) begin
      rom_value = 8'h01;
    end
    if (controller_kind == KIND_MBC1) begin
      if (rom_value == 8'h21) begin
        rom_value = 8'h20;
      end
      if (rom_value == 8'h41) begin
        rom_value = 8'h40;
      end
    end
  end

  always_comb begin
    rom_bank_next     = rom_bank;
    ram_mapped_next   = ram_mapped;
    mapped_bank_next  = mapped_bank;
    saved_valid_next  = saved_valid;
    saved_bank_next   = saved_bank;
    boot_overlay_next = boot_overlay;
    ctrl_taken        = 1'b0;
    region_next       = RGN_OPEN;
    offset_next       = '0;
    ignored_next      = 1'b0;

    if (req_type && !bus_address[15]) begin
      region_next = RGN_CTRL;
      offset_next = OFFSET_W'(bus_address);
      // boot rom blocks controller writes in the low 4 KiB
      if (!(bus_address < 16'h1000 && boot_overlay) && kind_ok) begin
        if (rom_win) begin
          rom_bank_next = rom_value;
          ctrl_taken    = 1'b1;
        end else if (en_win) begin
          if (write_data == RAM_OFF) begin
            saved_valid_next = ram_mapped;
            saved_bank_next  = mapped_bank;
            ram_mapped_next  = 1'b0;
            ctrl_taken       = 1'b1;
          end else if (write_data == RAM_ON) begin
            ram_mapped_next  = saved_valid && (bank_limit != '0);
            mapped_bank_next = saved_bank;
            ctrl_taken       = 1'b1;
          end
        end else if (ram_win && (write_data < DATA_W'(bank_limit))) begin
          ram_mapped_next  = 1'b1;
          mapped_bank_next = write_data[RAM_BANK_W-1:0];
          ctrl_taken       = 1'b1;
        end
      end
      ignored_next = !ctrl_taken;
    end else if (bus_address < 16'h4000) begin
      region_next = (bus_address < 16'h0100 && boot_overlay) ? RGN_BOOT : RGN_FIXED;
      offset_next = OFFSET_W'(bus_address);
    end else if (bus_address < 16'h8000) begin
      region_next = RGN_BANKED;
      offset_next = {rom_bank, bus_address[13:0]};
    end else if (bus_address < 16'hA000) begin
      region_next = RGN_VRAM;
      offset_next = OFFSET_W'(bus_address[12:0]);
    end else if (bus_address < 16'hC000) begin
      if (ram_mapped) begin
        region_next = RGN_CART;
        offset_next = OFFSET_W'({mapped_bank, bus_address[12:0]});
      end else begin
        region_next  = RGN_OPEN;
        offset_next  = '0;
        ignored_next = req_type;
      end
    end else if (bus_address < 16'hFF00) begin
      region_next = RGN_WRAM;
      offset_next = OFFSET_W'(bus_address[12:0]);
    end else if (bus_address < 16'hFF80) begin
      region_next = RGN_IO;
      offset_next = OFFSET_W'(bus_address[6:0]);
      if (req_type && bus_address == BOOT_OFF_ADDR) begin
        boot_overlay_next = 1'b0;
      end
    end else begin
      region_next = RGN_HRAM;
      offset_next = OFFSET_W'(bus_address[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_kind <= KIND_NONE;
      ram_bank_count  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_KIND:      controller_kind <= cfg_data[KIND_W-1:0];
        CFG_RAM_COUNT: ram_bank_count  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank     <= 8'h01;
      ram_mapped   <= 1'b0;
      mapped_bank  <= '0;
      saved_valid  <= 1'b1;
      saved_bank   <= '0;
      boot_overlay <= 1'b1;
    end else if (in_xfer) begin
      rom_bank     <= rom_bank_next;
      ram_mapped   <= ram_mapped_next;
      mapped_bank  <= mapped_bank_next;
      saved_valid  <= saved_valid_next;
      saved_bank   <= saved_bank_next;
      boot_overlay <= boot_overlay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register, loaded only when the slot is free or being drained
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      region  <= region_next;
      offset  <= offset_next;
      ignored <= ignored_next;
    end
  end

`include "cartridge_bank_address_mapper_top_assert.svh"

  `CBAM_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid, "input stalled with empty output")
  `CBAM_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid, "accepted access left no result")
  `CBAM_ASSERT_NOW(a_rom_bank_nonzero, 1'b1, rom_bank != '0, "rom bank register holds zero")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cartridge bank address mapper: a queue-fed
// driver and a monitor trade accesses and results under random idling,
// each result is checked against a bank state model kept in the bench
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbam_pkg::*;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam int CYCLE_LIMIT       = 100000;
  localparam int ITEMS_PER_SETTING = 135;
  localparam int NUM_SETTINGS      = 9;
  localparam int PRINT_CAP         = 40;

  localparam logic [DATA_W-1:0] ROM_PICKS [6] = '{8'h00, 8'h21, 8'h41, 8'h20, 8'h40, 8'hFF};

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } access_t;

  typedef struct packed {
    logic [REGION_W-1:0] rgn;
    logic [OFFSET_W-1:0] off;
    logic                ign;
  } mapping_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  req_type     = 1'b0;
  logic [ADDR_W-1:0]     bus_address  = '0;
  logic [DATA_W-1:0]     write_data   = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [REGION_W-1:0]   region;
  logic [OFFSET_W-1:0]   offset;
  logic                  ignored;

  cartridge_bank_address_mapper_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .bus_address  (bus_address),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .region       (region),
    .offset       (offset),
    .ignored      (ignored)
  );

  // bank control state as the bench sees it
  logic [KIND_W-1:0]     kind_q    = KIND_NONE;
  logic [COUNT_W-1:0]    bank_cnt  = '0;
  logic [7:0]            rom_bank  = 8'h01;
  logic                  ram_on    = 1'b0;
  logic [RAM_BANK_W-1:0] ram_sel   = '0;
  logic                  saved_ok  = 1'b1;
  logic [RAM_BANK_W-1:0] saved_sel = '0;
  logic                  boot_on   = 1'b1;

  access_t  access_queue [$];
  mapping_t expected_maps [$];

  int errors     = 0;
  int cycles     = 0;
  int n_taken    = 0;
  int n_writes   = 0;
  int n_dropped  = 0;
  int n_settings = 0;
  int region_hits [10];

  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;

  always #5 clk = ~clk;

  // decode one access and apply its effect on the bank state
  task automatic map_access(input access_t a, output mapping_t m);
    logic [DATA_W-1:0]  v;
    logic [COUNT_W-1:0] lim;
    logic               took;
    lim  = (bank_cnt > 3'd4) ? 3'd4 : bank_cnt;
    took = 1'b0;
    m.ign = 1'b0;
    m.off = '0;
    if (a.wr == REQ_WRITE && a.addr < 16'h8000) begin
      m.rgn = RGN_CTRL;
      m.off = OFFSET_W'(a.addr);
      if (a.addr < 16'h1000 && boot_on) begin
        took = 1'b0;
      end else if (kind_q == KIND_MBC1 || kind_q == KIND_MBC3) begin
        if (a.addr >= 16'h2000 && a.addr < 16'h3FFF) begin
          v = a.data;
          if (v == 8'h00) v = 8'h01;
          if (kind_q == KIND_MBC1 && v == 8'h21) v = 8'h20;
          if (kind_q == KIND_MBC1 && v == 8'h41) v = 8'h40;
          rom_bank = v;
          took = 1'b1;
        end else if (a.addr < 16'h1FFF) begin
          if (a.data == RAM_OFF) begin
            saved_ok  = ram_on;
            saved_sel = ram_sel;
            ram_on    = 1'b0;
            took      = 1'b1;
          end else if (a.data == RAM_ON) begin
            ram_on  = saved_ok && lim != 0;
            ram_sel = saved_sel;
            took    = 1'b1;
          end
        end else if (kind_q == KIND_MBC3 && a.addr >= 16'h4000 && a.addr < 16'h5FFF) begin
          if (a.data < lim) begin
            ram_on  = 1'b1;
            ram_sel = a.data[RAM_BANK_W-1:0];
            took    = 1'b1;
          end
        end
      end
      m.ign = !took;
    end else if (a.addr < 16'h4000) begin
      m.rgn = (a.addr < 16'h0100 && boot_on) ? RGN_BOOT : RGN_FIXED;
      m.off = OFFSET_W'(a.addr);
    end else if (a.addr < 16'h8000) begin
      m.rgn = RGN_BANKED;
      m.off = {rom_bank, a.addr[13:0]};
    end else if (a.addr < 16'hA000) begin
      m.rgn = RGN_VRAM;
      m.off = OFFSET_W'(a.addr[12:0]);
    end else if (a.addr < 16'hC000) begin
      if (ram_on) begin
        m.rgn = RGN_CART;
        m.off = OFFSET_W'({ram_sel, a.addr[12:0]});
      end else begin
        m.rgn = RGN_OPEN;
        m.ign = a.wr;
      end
    end else if (a.addr < 16'hFF00) begin
      m.rgn = RGN_WRAM;
      m.off = OFFSET_W'(a.addr[12:0]);
    end else if (a.addr < 16'hFF80) begin
      m.rgn = RGN_IO;
      m.off = OFFSET_W'(a.addr[6:0]);
      if (a.wr == REQ_WRITE && a.addr == BOOT_OFF_ADDR) boot_on = 1'b0;
    end else begin
      m.rgn = RGN_HRAM;
      m.off = OFFSET_W'(a.addr[6:0]);
    end
  endtask

  // idle cycles before the next item; now and then switch to a no-idle stretch
  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 31) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic access_t random_access();
    access_t r;
    r.wr   = 1'($urandom_range(0, 1));
    r.data = DATA_W'($urandom);
    r.addr = ADDR_W'($urandom);
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        r.wr   = REQ_WRITE;
        r.addr = ADDR_W'($urandom_range(16'h0000, 16'h1FFF));
        case ($urandom_range(0, 3))
          0:       r.data = RAM_OFF;
          1, 2:    r.data = RAM_ON;
          default: ;
        endcase
      end
      3, 4: begin
        r.wr   = REQ_WRITE;
        r.addr = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
        if ($urandom_range(0, 1) == 0) r.data = ROM_PICKS[3'($urandom_range(0, 5))];
      end
      5, 6: begin
        r.wr   = REQ_WRITE;
        r.addr = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
        if ($urandom_range(0, 3) != 0) r.data = DATA_W'($urandom_range(0, 7));
      end
      7: begin
        r.wr   = REQ_WRITE;
        r.addr = ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
      end
      8: begin
        // window edges
        r.wr = REQ_WRITE;
        case ($urandom_range(0, 6))
          0:       r.addr = 16'h1FFF;
          1:       r.addr = 16'h1FFE;
          2:       r.addr = 16'h3FFF;
          3:       r.addr = 16'h3FFE;
          4:       r.addr = 16'h5FFF;
          5:       r.addr = 16'h5FFE;
          default: r.addr = 16'h6000;
        endcase
      end
      9, 10, 11: r.addr = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
      12:        r.addr = ADDR_W'($urandom_range(16'h4000, 16'h7FFF));
      13:        r.addr = ADDR_W'($urandom_range(16'hFF00, 16'hFFFF));
      default:   ;
    endcase
    return r;
  endfunction

  task automatic add_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    access_t a;
    a.wr   = wr;
    a.addr = addr;
    a.data = data;
    access_queue.push_back(a);
  endtask

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("error %0d at cycle %0d: %s", errors, cycles, msg);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (access_queue.size() != 0 || in_valid || expected_maps.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_config(input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] cnt);
    wait_idle();
    repeat (2) @(posedge clk);
    write_reg(CFG_KIND, CFG_DATA_W'(kind));
    kind_q = kind;
    write_reg(CFG_RAM_COUNT, cnt);
    bank_cnt = cnt;
    n_settings++;
    @(negedge clk);
  endtask

  // driver: one item on the bus at a time, random gap after each transfer
  int      gap_left = 0;
  access_t on_bus;

  always @(posedge clk) begin : drive
    mapping_t m;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        map_access(on_bus, m);
        expected_maps.push_back(m);
        n_taken++;
        if (on_bus.wr == REQ_WRITE) n_writes++;
        if (m.ign) n_dropped++;
        region_hits[m.rgn]++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (access_queue.size() > 0) begin
          on_bus = access_queue.pop_front();
          req_type    <= on_bus.wr;
          bus_address <= on_bus.addr;
          write_data  <= on_bus.data;
          in_valid    <= 1'b1;
          gap_left = draw_wait(src_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, then stall for a random count
  int stall_left = 0;

  always @(posedge clk) begin : watch
    mapping_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_maps.size() == 0) begin
          flag_mismatch($sformatf("unexpected result region %0d offset 0x%06h", region, offset));
        end else begin
          want = expected_maps.pop_front();
          if (region !== want.rgn)
            flag_mismatch($sformatf("region %0d, want %0d", region, want.rgn));
          if (offset !== want.off)
            flag_mismatch($sformatf("offset 0x%06h, want 0x%06h", offset, want.off));
          if (ignored !== want.ign)
            flag_mismatch($sformatf("ignored %0b, want %0b", ignored, want.ign));
        end
        stall_left = draw_wait(snk_steady);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycles, expected_maps.size());
      $display("cartridge_bank_address_mapper_top: mismatch");
      $finish;
    end
  end

  logic [KIND_W-1:0]  setting_kind [NUM_SETTINGS] =
    '{KIND_MBC1, KIND_MBC3, KIND_MBC3, KIND_NOP, KIND_MBC1, KIND_NONE, KIND_MBC3, KIND_MBC3,
      KIND_MBC3};
  logic [COUNT_W-1:0] setting_cnt [NUM_SETTINGS] =
    '{3'd4, 3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd1, 3'd6, 3'd5};

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // boot overlay with no controller
    add_access(REQ_READ,  16'h0000, 8'h00);
    add_access(REQ_READ,  16'h00FF, 8'h00);
    add_access(REQ_READ,  16'h0100, 8'h00);
    add_access(REQ_WRITE, 16'h0000, RAM_ON);
    add_access(REQ_WRITE, 16'h2000, 8'h05);

    set_config(KIND_MBC3, 3'd4);
    add_access(REQ_WRITE, 16'h0FFF, RAM_ON);
    add_access(REQ_WRITE, 16'h1000, RAM_ON);
    add_access(REQ_WRITE, 16'h4000, 8'h03);
    add_access(REQ_WRITE, 16'hBFFF, 8'hFF);
    add_access(REQ_WRITE, 16'h5FFF, 8'h01);
    add_access(REQ_WRITE, 16'h5FFE, 8'h04);
    add_access(REQ_WRITE, 16'h6000, 8'h01);
    add_access(REQ_WRITE, 16'h1FFF, RAM_OFF);
    add_access(REQ_WRITE, 16'h1FFE, RAM_OFF);
    add_access(REQ_WRITE, 16'hA123, 8'h55);
    add_access(REQ_WRITE, 16'h3FFF, 8'h05);
    add_access(REQ_WRITE, 16'h3FFE, 8'hFF);
    add_access(REQ_READ,  16'h7FFF, 8'h00);
    add_access(REQ_WRITE, BOOT_OFF_ADDR, 8'h01);
    add_access(REQ_READ,  16'h0000, 8'h00);
    add_access(REQ_WRITE, 16'h0000, RAM_ON);
    add_access(REQ_READ,  16'hA000, 8'h00);
    add_access(REQ_READ,  16'h9FFF, 8'h00);
    add_access(REQ_READ,  16'hFEFF, 8'h00);
    add_access(REQ_READ,  16'hFFFF, 8'h00);

    // mbc1 bank remaps
    set_config(KIND_MBC1, 3'd4);
    add_access(REQ_WRITE, 16'h2000, 8'h21);
    add_access(REQ_READ,  16'h4000, 8'h00);
    add_access(REQ_WRITE, 16'h3000, 8'h41);
    add_access(REQ_READ,  16'h5000, 8'h00);
    add_access(REQ_WRITE, 16'h2000, 8'h00);
    add_access(REQ_READ,  16'h7000, 8'h00);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      set_config(setting_kind[p], setting_cnt[p]);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        access_queue.push_back(random_access());
        // let the mapper drain completely before the rest of this setting
        if (i == ITEMS_PER_SETTING / 2 && p % 3 == 1) wait_idle();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("%0d accesses (%0d writes, %0d without effect) over %0d controller settings",
             n_taken, n_writes, n_dropped, n_settings);
    $display("hits: boot %0d fixed %0d banked %0d cart %0d open %0d io %0d control %0d",
             region_hits[RGN_BOOT], region_hits[RGN_FIXED], region_hits[RGN_BANKED],
             region_hits[RGN_CART], region_hits[RGN_OPEN], region_hits[RGN_IO],
             region_hits[RGN_CTRL]);
    if (errors == 0) begin
      $display("cartridge_bank_address_mapper_top: match");
    end else begin
      $display("cartridge_bank_address_mapper_top: mismatch");
    end
    $finish;
  end

endmodule
